// File: sv/rmi_pkg.sv
// ----------------------------------------------------------------------------
// rmi_pkg: shared types and codes for the mask-to-index block
// Field widths, opcode and mask codes, channel payload structs, register map.
// ----------------------------------------------------------------------------
package rmi_pkg;

  localparam int MASK_DEPTH_DEF = 1024;

  localparam int TLEN_W = 31;   // target length, positions, counts
  localparam int OP_W   = 2;
  localparam int MV_W   = 2;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [CFG_AW-3:0] REG_TARGET_LENGTH = '0;

  // opcodes
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_STEP   = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

  // mask entry codes; anything else reads as missing
  localparam logic [MV_W-1:0] MV_FALSE = 2'd0;
  localparam logic [MV_W-1:0] MV_TRUE  = 2'd1;

  typedef struct packed {
    logic [OP_W-1:0] opcode;
    logic [MV_W-1:0] mask_value;
  } in_item_t;

  typedef struct packed {
    logic [TLEN_W-1:0] position;
    logic              selected;
    logic              is_missing;
    logic              final_position;
    logic              walk_done;
    logic [TLEN_W-1:0] emitted_count;
  } out_item_t;

endpackage

// File: sv/rmi_chan_if.sv
// ----------------------------------------------------------------------------
// rmi_chan_if: valid/ready channel
// One transfer per clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface rmi_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/rmi_ram.sv
// ----------------------------------------------------------------------------
// rmi_ram: simple dual-port RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module rmi_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// File: sv/recycled_mask_to_index.sv
// ----------------------------------------------------------------------------
// recycled_mask_to_index: logical mask to index compaction with recycling
// Holds a mask store and walks target positions, one result per step item.
// ----------------------------------------------------------------------------
// Usage
//   in_chan  : items {opcode, mask_value}. Clear empties the mask and restarts
//              the walk, append stores one mask entry, step examines one
//              position, opcode 3 is a no-op. Only steps produce a result.
//   out_chan : one result per step: position, selected, is_missing,
//              final_position, walk_done and the running emitted_count.
//   APB port : target_length at byte address 0; write while the block is idle.
// Timing
//   One item per cycle sustained while the receiver takes results. A step's
//   result passes the mask store read, which registers at the transfer edge
//   along with the read stage, and then the result register, which loads as
//   the read stage moves on. The single RAM read port sets the one-per-cycle figure.
// Reset (rst_n low, synchronous)
//   Empties the mask and the walk, clears target_length and drops all
//   in-flight items. The mask RAM itself is not cleared: entries are only used
//   below the fill count, so no clearing pass is needed.
// Stall
//   A held result stays on out_chan; one more step is absorbed in the read
//   stage (clears and appends flow through it), then in_chan.ready drops
//   until the receiver takes the result.
// ----------------------------------------------------------------------------
module recycled_mask_to_index #(
  parameter int MASK_DEPTH = rmi_pkg::MASK_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  rmi_chan_if.sink                   in_chan,
  rmi_chan_if.source                 out_chan,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rmi_pkg::CFG_AW-1:0] paddr,
  input  logic [rmi_pkg::CFG_DW-1:0] pwdata,
  output logic [rmi_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);
  import rmi_pkg::*;

  localparam int CNT_W = $clog2(MASK_DEPTH + 1);
  localparam int AW    = (MASK_DEPTH > 1) ? $clog2(MASK_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(MASK_DEPTH);

  // read-stage record, one per accepted item
  typedef struct packed {
    logic              is_step;
    logic              is_clear;
    logic              done;      // step came after the walk ended
    logic              beyond;    // position past the target: forced missing
    logic              fin;
    logic [TLEN_W-1:0] position;
  } rd_stage_t;

  // ---------------- configuration ----------------
  logic              reg_sel;
  logic              cfg_wr;
  logic [TLEN_W-1:0] target_len_r;

  assign reg_sel = (paddr[CFG_AW-1:2] == REG_TARGET_LENGTH);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? CFG_DW'(target_len_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_len_r <= '0;
    end else if (cfg_wr && reg_sel) begin
      target_len_r <= pwdata[TLEN_W-1:0];
    end
  end

  // ---------------- accept stage: walk bookkeeping ----------------
  logic [CNT_W-1:0]  mask_count_r, mask_count_nxt;
  logic [AW-1:0]     mask_ptr_r, mask_ptr_nxt;
  logic [TLEN_W-1:0] walk_pos_r, walk_pos_nxt;

  in_item_t          in_d;
  logic              accept;
  logic [TLEN_W-1:0] count_ext;
  logic [TLEN_W-1:0] walk_len;
  logic              done;
  logic              beyond;
  logic [AW-1:0]     ptr_eff;
  logic [AW-1:0]     ptr_base;
  logic [CNT_W-1:0]  ptr_inc;
  logic [AW-1:0]     ptr_wrap;
  logic [TLEN_W-1:0] pos_inc;
  logic              full;
  logic              ram_we;
  logic              ram_re;
  logic [MV_W-1:0]   ram_rdata;

  rd_stage_t         s1_r, s1_nxt;
  logic              s1_valid_r;
  logic              s1_go;
  logic              out_free;
  logic              out_valid_r;
  out_item_t         out_data_r;

  assign in_d   = in_chan.data;
  assign accept = in_chan.valid && in_chan.ready;

  // walk covers max(target, mask) positions; an empty mask gives no walk
  assign count_ext = TLEN_W'(mask_count_r);
  assign walk_len  = (mask_count_r == '0) ? '0 :
                     ((target_len_r >= count_ext) ? target_len_r : count_ext);
  assign done      = (walk_pos_r >= walk_len);
  assign beyond    = (walk_pos_r >= target_len_r);

  // wrapping pointer: a stale pointer restarts at zero before the read,
  // but past the target the raw pointer is advanced
  assign ptr_eff  = (CNT_W'(mask_ptr_r) >= mask_count_r) ? '0 : mask_ptr_r;
  assign ptr_base = beyond ? mask_ptr_r : ptr_eff;
  assign ptr_inc  = CNT_W'(ptr_base) + CNT_W'(1);
  assign ptr_wrap = (ptr_inc >= mask_count_r) ? '0 : ptr_inc[AW-1:0];
  assign pos_inc  = walk_pos_r + TLEN_W'(1);

  assign full   = (mask_count_r >= DEPTH_C);
  assign ram_we = accept && (in_d.opcode == OP_APPEND) && !full;
  assign ram_re = accept && (in_d.opcode == OP_STEP);

  always_comb begin
    mask_count_nxt = mask_count_r;
    mask_ptr_nxt   = mask_ptr_r;
    walk_pos_nxt   = walk_pos_r;
    s1_nxt         = '0;
    case (in_d.opcode)
      OP_CLEAR: begin
        mask_count_nxt  = '0;
        mask_ptr_nxt    = '0;
        walk_pos_nxt    = '0;
        s1_nxt.is_clear = 1'b1;
      end
      OP_APPEND: begin
        if (!full) begin
          mask_count_nxt = mask_count_r + CNT_W'(1);
        end
      end
      OP_STEP: begin
        s1_nxt.is_step = 1'b1;
        s1_nxt.done    = done;
        if (!done) begin
          s1_nxt.beyond   = beyond;
          s1_nxt.fin      = (pos_inc == walk_len);
          s1_nxt.position = walk_pos_r;
          mask_ptr_nxt    = ptr_wrap;
          walk_pos_nxt    = pos_inc;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_count_r <= '0;
      mask_ptr_r   <= '0;
      walk_pos_r   <= '0;
    end else if (accept) begin
      mask_count_r <= mask_count_nxt;
      mask_ptr_r   <= mask_ptr_nxt;
      walk_pos_r   <= walk_pos_nxt;
    end
  end

  rmi_ram #(
    .WIDTH (MV_W),
    .DEPTH (MASK_DEPTH),
    .AW    (AW)
  ) u_mask_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (mask_count_r[AW-1:0]),
    .wdata (in_d.mask_value),
    .re    (ram_re),
    .raddr (ptr_eff),
    .rdata (ram_rdata)
  );

  // ---------------- read stage ----------------
  // Non-step items pass freely; a step waits for a free result register.
  // RAM read data holds while a step sits here, since no new read is issued.
  assign out_free      = !out_valid_r || out_chan.ready;
  assign s1_go         = s1_valid_r && (!s1_r.is_step || out_free);
  assign in_chan.ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_nxt;
    end
  end

  logic              sel;
  logic              miss;
  logic [TLEN_W-1:0] emitted_r, emitted_nxt;
  out_item_t         out_nxt;

  always_comb begin
    sel  = 1'b0;
    miss = 1'b0;
    if (!s1_r.done) begin
      if (s1_r.beyond) begin
        sel  = 1'b1;
        miss = 1'b1;
      end else if (ram_rdata == MV_TRUE) begin
        sel = 1'b1;
      end else if (ram_rdata != MV_FALSE) begin
        sel  = 1'b1;
        miss = 1'b1;
      end
    end
  end

  always_comb begin
    emitted_nxt = emitted_r;
    if (s1_r.is_clear) begin
      emitted_nxt = '0;
    end else if (s1_r.is_step && sel) begin
      emitted_nxt = emitted_r + TLEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emitted_r <= '0;
    end else if (s1_go) begin
      emitted_r <= emitted_nxt;
    end
  end

  // ---------------- result register ----------------
  always_comb begin
    out_nxt.position       = s1_r.position;
    out_nxt.selected       = sel;
    out_nxt.is_missing     = miss;
    out_nxt.final_position = s1_r.fin;
    out_nxt.walk_done      = s1_r.done;
    out_nxt.emitted_count  = emitted_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_r.is_step) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_r.is_step) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

endmodule

// File: sv/rmi_checker.sv
// ----------------------------------------------------------------------------
// rmi_checker: port-level checks for the mask-to-index block
// Watches the channel ports; attached to the top level by bind.
// ----------------------------------------------------------------------------
module rmi_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input rmi_pkg::out_item_t out_data
);
  import rmi_pkg::*;

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // input backpressure only comes from a held result
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled without a pending result");

  // a step after the walk reports nothing but the count
  a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.walk_done |->
      !out_data.selected && !out_data.is_missing &&
      !out_data.final_position && (out_data.position == '0))
    else $error("walk_done result carries position data");

  // missing only on a selected position
  a_miss_sel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_missing |-> out_data.selected)
    else $error("missing flag on unselected position");

endmodule

bind recycled_mask_to_index rmi_checker u_rmi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_data  (out_chan.data)
);

// File: tb/sv/recycled_mask_to_index_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// recycled_mask_to_index_tb: self-checking bench for mask-to-index compaction
// Drives clear/append/step/no-op transfers with random gaps on both channels,
// predicts every step result from a private copy of the mask and walk state,
// and checks each result field by field. target_length goes through 0, 1, the
// 31-bit maximum and random values. One phase fills the mask to its limit.
// ----------------------------------------------------------------------------
module recycled_mask_to_index_tb;
  import rmi_pkg::*;

  localparam int          MASK_DEPTH   = MASK_DEPTH_DEF;
  localparam int          HALF_PERIOD  = 2;
  localparam int          SETTLE       = 6;    // pipeline is two deep; margin added
  localparam int          HOLD_CYCLES  = 300;  // long receiver hold-off
  localparam int          STALL_LIMIT  = 2000; // cycles without any transfer
  localparam int          RANDOM_ITEMS = 650;
  localparam int          DIR_ROWS     = 24;
  localparam logic [30:0] TLEN_MAX     = 31'h7FFF_FFFF;

  // mask codes beyond the package ones: both read back as missing
  localparam logic [MV_W-1:0] MV_MISSING = 2'd2;
  localparam logic [MV_W-1:0] MV_SPARE   = 2'd3;

  // one row of the directed table: a register write or an input transfer,
  // optionally with its result typed in
  typedef struct packed {
    bit          is_cfg;
    logic [30:0] cfg_val;
    in_item_t    item;
    bit          fixed;
    out_item_t   res;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CFG_AW-1:0]   paddr;
  logic [CFG_DW-1:0]   pwdata;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;

  rmi_chan_if #(.T(in_item_t))  in_if ();
  rmi_chan_if #(.T(out_item_t)) out_if ();

  recycled_mask_to_index dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #HALF_PERIOD clk = ~clk;

  // --------------------------------------------------------------------------
  // Walk predictor: own copy of mask store, fill count, pointer and counters
  // --------------------------------------------------------------------------
  logic [MV_W-1:0] mask_mem [MASK_DEPTH];
  int unsigned     mask_fill  = 0;
  int unsigned     mask_ptr   = 0;
  logic [30:0]     walk_pos   = '0;
  logic [30:0]     emit_total = '0;
  logic [30:0]     tgt_len    = '0;

  out_item_t       step_results_due [$];

  // run statistics
  int unsigned effective_items = 0;  // clears, stored appends, steps
  int unsigned appends_stored  = 0;
  int unsigned appends_dropped = 0;
  int unsigned clears_sent     = 0;
  int unsigned cfg_writes      = 0;
  int unsigned steps_checked   = 0;
  int unsigned done_seen       = 0;
  int unsigned sel_seen        = 0;
  int unsigned miss_seen       = 0;
  int unsigned mismatches      = 0;

  // idling control shared by sender and receiver
  bit burst    = 1'b0;  // no gaps on either side
  bit hold_req = 1'b0;
  bit holding  = 1'b0;

  // Applies one accepted item to the predicted state. Returns 1 with the
  // expected result for a step, 0 for everything that yields nothing.
  function automatic bit walk_item(input in_item_t it, output out_item_t r);
    int unsigned len;
    int unsigned pos;
    r = '0;
    case (it.opcode)
      OP_CLEAR: begin
        mask_fill  = 0;
        mask_ptr   = 0;
        walk_pos   = '0;
        emit_total = '0;
        clears_sent++;
        effective_items++;
        return 1'b0;
      end
      OP_APPEND: begin
        if (mask_fill < MASK_DEPTH) begin
          mask_mem[mask_fill] = it.mask_value;
          mask_fill++;
          appends_stored++;
          effective_items++;
        end else begin
          appends_dropped++;  // full mask: ignored
        end
        return 1'b0;
      end
      OP_STEP: effective_items++;
      default: return 1'b0;
    endcase

    // empty mask gives a zero-length walk; otherwise max(target, mask)
    len = (mask_fill == 0) ? 0 : ((tgt_len >= mask_fill) ? tgt_len : mask_fill);
    if (walk_pos >= len) begin
      r.walk_done     = 1'b1;
      r.emitted_count = emit_total;
      return 1'b1;
    end

    pos = walk_pos;
    if (pos >= tgt_len) begin
      // mask longer than target: trailing positions are missing
      r.selected   = 1'b1;
      r.is_missing = 1'b1;
    end else begin
      if (mask_ptr >= mask_fill) mask_ptr = 0;  // mask shrank or pointer ran off
      case (mask_mem[mask_ptr])
        MV_FALSE: ;
        MV_TRUE:  r.selected = 1'b1;
        default: begin
          r.selected   = 1'b1;
          r.is_missing = 1'b1;
        end
      endcase
    end

    // pointer advances on every walked position, trailing ones included
    mask_ptr++;
    if (mask_ptr >= mask_fill) mask_ptr = 0;

    if (r.selected) emit_total = emit_total + 31'd1;
    r.final_position = (pos + 1 == len);
    walk_pos         = 31'(pos + 1);
    r.position       = 31'(pos);
    r.emitted_count  = emit_total;
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Directed table helpers
  // --------------------------------------------------------------------------
  function automatic out_item_t fixed_res(input logic [30:0] pos, input bit sel,
                                          input bit miss, input bit fin,
                                          input bit done, input logic [30:0] cnt);
    out_item_t r;
    r.position       = pos;
    r.selected       = sel;
    r.is_missing     = miss;
    r.final_position = fin;
    r.walk_done      = done;
    r.emitted_count  = cnt;
    return r;
  endfunction

  function automatic dir_row_t in_row(input logic [OP_W-1:0] op,
                                      input logic [MV_W-1:0] mv);
    dir_row_t d;
    d = '0;
    d.item.opcode     = op;
    d.item.mask_value = mv;
    return d;
  endfunction

  function automatic dir_row_t chk_row(input logic [OP_W-1:0] op,
                                       input logic [MV_W-1:0] mv,
                                       input out_item_t res);
    dir_row_t d;
    d       = in_row(op, mv);
    d.fixed = 1'b1;
    d.res   = res;
    return d;
  endfunction

  function automatic dir_row_t cfg_row(input logic [30:0] v);
    dir_row_t d;
    d         = '0;
    d.is_cfg  = 1'b1;
    d.cfg_val = v;
    return d;
  endfunction

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // random mask code, any of the four
  function automatic logic [MV_W-1:0] rand_mv();
    return MV_W'($urandom_range(0, 3));
  endfunction

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  // valid stays high across back-to-back transfers; it only drops for a gap
  task automatic send_item(input in_item_t it, input bit fixed, input out_item_t fixed_r);
    int unsigned gap;
    out_item_t   pred;
    gap = pick_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk); while (!in_if.ready);
    // transfer happened at this edge
    if (walk_item(it, pred)) step_results_due.push_back(fixed ? fixed_r : pred);
  endtask

  task automatic send_op(input logic [OP_W-1:0] op, input logic [MV_W-1:0] mv);
    in_item_t it;
    it.opcode     = op;
    it.mask_value = mv;
    send_item(it, 1'b0, '0);
  endtask

  // Register write only with the block idle: all results in, plus a settling
  // wait for clears/appends still in the pipe.
  task automatic write_target_length(input logic [30:0] value);
    in_if.valid <= 1'b0;
    while (step_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_TARGET_LENGTH, 2'b00};
    pwdata  <= {1'b0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tgt_len = value;
    cfg_writes++;
  endtask

  // One random phase: usually a clear, a mask load, then a walk with a few
  // appends/no-ops/clears mixed in. Now and then pure noise instead.
  task automatic run_random_phase(input int unsigned idx);
    in_item_t    it;
    int unsigned n_mask;
    int unsigned n_steps;
    int unsigned len;
    int unsigned pick;
    burst = (idx % 5 == 2);

    if ($urandom_range(0, 9) < 7) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0:       write_target_length('0);
        1:       write_target_length(31'd1);
        2:       write_target_length(TLEN_MAX);
        3:       write_target_length(31'($urandom()));
        default: write_target_length(31'($urandom_range(1, 40)));
      endcase
    end

    if ($urandom_range(0, 6) == 0) begin
      // broken sequences: any opcode, any mask code
      repeat ($urandom_range(10, 40)) begin
        it.opcode     = OP_W'($urandom_range(0, 3));
        it.mask_value = rand_mv();
        send_item(it, 1'b0, '0);
      end
      return;
    end

    // skipping the clear sometimes keeps an old walk going
    if ($urandom_range(0, 9) != 0) send_op(OP_CLEAR, rand_mv());

    n_mask = ($urandom_range(0, 9) == 0) ? 0 :
             $urandom_range(1, ($urandom_range(0, 3) == 0) ? 64 : 12);
    repeat (n_mask) send_op(OP_APPEND, rand_mv());

    // walk to the end and a little past it, unless the walk is long
    len     = (mask_fill == 0) ? 0 : ((tgt_len >= mask_fill) ? tgt_len : mask_fill);
    n_steps = (len > 48) ? $urandom_range(8, 48) : len + $urandom_range(0, 3);
    repeat (n_steps) begin
      pick = $urandom_range(0, 99);
      if (pick < 6)       send_op(OP_APPEND, rand_mv());
      else if (pick < 8)  send_op(OP_NOP, rand_mv());
      else if (pick < 9)  send_op(OP_CLEAR, rand_mv());
      else                send_op(OP_STEP, rand_mv());
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    dir_row_t    dir_rows [DIR_ROWS];
    int unsigned start_items;
    int unsigned phase;

    rst_n       <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;

    dir_rows = '{
      cfg_row('0),
      // empty mask: walk already over
      chk_row(OP_STEP,   MV_FALSE, fixed_res(31'd0, 1'b0, 1'b0, 1'b0, 1'b1, 31'd0)),
      in_row (OP_NOP,    MV_SPARE),
      in_row (OP_APPEND, MV_TRUE),
      // target 0, one entry: the only position is trailing, so missing
      chk_row(OP_STEP,   MV_FALSE, fixed_res(31'd0, 1'b1, 1'b1, 1'b1, 1'b0, 31'd1)),
      chk_row(OP_STEP,   MV_FALSE, fixed_res(31'd0, 1'b0, 1'b0, 1'b0, 1'b1, 31'd1)),
      in_row (OP_CLEAR,  MV_FALSE),
      // mask of four recycled over a target of six
      cfg_row(31'd6),
      in_row (OP_APPEND, MV_FALSE),
      in_row (OP_APPEND, MV_TRUE),
      in_row (OP_APPEND, MV_MISSING),
      in_row (OP_APPEND, MV_SPARE),
      in_row (OP_STEP,   MV_FALSE),
      in_row (OP_STEP,   MV_SPARE),
      in_row (OP_STEP,   MV_TRUE),
      // append mid-walk: pointer now wraps at five
      in_row (OP_APPEND, MV_TRUE),
      in_row (OP_STEP,   MV_MISSING),
      in_row (OP_STEP,   MV_FALSE),
      in_row (OP_STEP,   MV_FALSE),
      in_row (OP_STEP,   MV_FALSE),
      // widest target resumes the finished walk
      cfg_row(TLEN_MAX),
      in_row (OP_STEP,   MV_FALSE),
      in_row (OP_CLEAR,  MV_SPARE),
      chk_row(OP_STEP,   MV_SPARE, fixed_res(31'd0, 1'b0, 1'b0, 1'b0, 1'b1, 31'd0))
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_target_length(dir_rows[i].cfg_val);
      else send_item(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].res);
    end

    // Fill the mask to its limit; the two extra appends must be dropped.
    // Then walk while the receiver holds off, so the block backs up.
    write_target_length(31'd3);
    send_op(OP_CLEAR, MV_FALSE);
    repeat (MASK_DEPTH + 2) send_op(OP_APPEND, rand_mv());
    in_if.valid <= 1'b0;
    hold_req = 1'b1;
    wait (holding);
    repeat (40) send_op(OP_STEP, rand_mv());

    start_items = effective_items;
    phase       = 0;
    while (effective_items - start_items < RANDOM_ITEMS) begin
      run_random_phase(phase);
      phase++;
    end
    burst = 1'b0;

    in_if.valid <= 1'b0;
    while (step_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d steps (%0d after walk end, %0d selected, %0d missing) in %0d phases",
             steps_checked, done_seen, sel_seen, miss_seen, phase);
    $display("mask: %0d appends stored, %0d dropped when full, %0d clears, %0d target writes",
             appends_stored, appends_dropped, clears_sent, cfg_writes);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: random ready pattern, one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned gap;
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      if (hold_req) begin
        holding = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        holding  = 1'b0;
      end else begin
        gap = pick_gap();
        if (gap != 0) begin
          out_if.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // values sampled here are the ones before the edge
  always @(posedge clk) begin : result_check
    out_item_t want;
    out_item_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (step_results_due.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected: position %0d done %0b count %0d",
                 $time, got.position, got.walk_done, got.emitted_count);
      end else begin
        want = step_results_due.pop_front();
        check_field("position",       want.position,       got.position);
        check_field("selected",       want.selected,       got.selected);
        check_field("is_missing",     want.is_missing,     got.is_missing);
        check_field("final_position", want.final_position, got.final_position);
        check_field("walk_done",      want.walk_done,      got.walk_done);
        check_field("emitted_count",  want.emitted_count,  got.emitted_count);
      end
      steps_checked++;
      if (got.walk_done)  done_seen++;
      if (got.selected)   sel_seen++;
      if (got.is_missing) miss_seen++;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: any transfer or register access restarts the count
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t: no transfer for %0d cycles, %0d results outstanding",
             $time, STALL_LIMIT, step_results_due.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
